// ----- rtl/light_dip_counter_defines.svh -----
// Assertion macros shared by the light dip counter RTL.
// Needs a clock named clock and a reset named reset in the using module.
`ifndef LIGHT_DIP_COUNTER_DEFINES_SVH
`define LIGHT_DIP_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
`define LDC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define LDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LDC_ASSERT_IMPL(label, ante, cons, msg)
`define LDC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/ldc_pkg.sv -----
// Shared types and constants of the light dip counter.
// No dependencies.
`default_nettype none
package ldc_pkg;
   localparam int WIN_W          = 11;
   localparam int SAMPLE_W       = 12;
   localparam int WEIGHT_W       = 16;
   localparam int THR_W          = 12;
   localparam int FRAC_W         = 16;
   localparam int LEVEL_W        = SAMPLE_W + FRAC_W;
   localparam int DIPS_W         = 10;
   localparam int TOTAL_W        = 32;
   localparam int CSR_ADDR_W     = 4;
   localparam int CSR_DATA_W     = 32;
   localparam int QDEPTH         = 2;
   localparam int MAX_WINDOW_DEF = 1024;

   localparam logic [WIN_W-1:0]    WINDOW_RST = 11'd1000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd66;
   localparam logic [THR_W-1:0]    THR_RST    = 12'd228;
   localparam logic [THR_W-1:0]    REARM_RST  = 12'd68;

   localparam logic [1:0] REG_WINDOW = 2'd0;
   localparam logic [1:0] REG_WEIGHT = 2'd1;
   localparam logic [1:0] REG_THR    = 2'd2;
   localparam logic [1:0] REG_REARM  = 2'd3;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_QUERY  = 1'b1
   } ldc_op_type;

   typedef struct packed {
      ldc_op_type          op;
      logic [SAMPLE_W-1:0] sample;
   } ldc_item_type;

   typedef struct packed {
      logic [WIN_W-1:0]    window;
      logic                window_wr;
      logic [WEIGHT_W-1:0] weight;
      logic [THR_W-1:0]    thr;
      logic [THR_W-1:0]    rearm;
   } ldc_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_WALK,
      ST_RESP
   } ldc_state_type;
endpackage
`default_nettype wire

// ----- rtl/ldc_front.sv -----
// Front end: takes commands, tags them by kind, holds them in a two-entry queue.
// Depends on ldc_pkg and light_dip_counter_defines.svh.
`default_nettype none
`include "light_dip_counter_defines.svh"
module ldc_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire                          req_kind,
   input  wire [ldc_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                         q_valid,
   output ldc_pkg::ldc_item_type        q_item,
   input  wire                          q_pop
);
   import ldc_pkg::*;

   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   ldc_item_type        entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   ldc_item_type        push_item;

   assign busy      = (count_ff == QCNT_W'(QDEPTH));
   assign push      = start && !busy;
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[head_ff];
   assign push_item = '{op: (req_kind ? OP_QUERY : OP_SAMPLE), sample: req_sample};

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == QPTR_W'(QDEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (q_pop && q_valid) begin
         head_in = (head_ff == QPTR_W'(QDEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !(q_pop && q_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop && q_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_item;
      end
   end

   `LDC_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
   `LDC_ASSERT_NEXT(a_push_count, push && !q_pop, count_ff == $past(count_ff) + 1'b1, "count slip")
   `LDC_ASSERT_IMPL(a_ptr_match, count_ff == '0, head_ff == tail_ff, "empty queue pointers differ")
endmodule
`default_nettype wire

// ----- rtl/ldc_back.sv -----
// Back end: history ring, moving average and the dip walk over the ring.
// Depends on ldc_pkg and light_dip_counter_defines.svh.
`default_nettype none
`include "light_dip_counter_defines.svh"
module ldc_back #(
   parameter int MAX_WINDOW = ldc_pkg::MAX_WINDOW_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  ldc_pkg::ldc_cfg_type         cfg,
   input  wire                          q_valid,
   input  ldc_pkg::ldc_item_type        q_item,
   output logic                         q_pop,
   output logic                         rsp_strobe,
   output logic [ldc_pkg::DIPS_W-1:0]   rsp_dip_count,
   output logic [ldc_pkg::SAMPLE_W-1:0] rsp_average,
   output logic [ldc_pkg::WIN_W-1:0]    rsp_samples_held,
   output logic [ldc_pkg::TOTAL_W-1:0]  rsp_samples_taken
);
   import ldc_pkg::*;

   localparam int WIN_MAX = (2 ** WIN_W) - 1;
   localparam int DEPTH   = (MAX_WINDOW < WIN_MAX) ? MAX_WINDOW : WIN_MAX;
   localparam int AW      = $clog2(DEPTH);
   localparam int PROD_W  = WEIGHT_W + LEVEL_W + 2;
   localparam int DIFF_W  = LEVEL_W + 2;

   ldc_state_type          state_ff, state_in;
   logic [SAMPLE_W-1:0]    ring [DEPTH];
   logic [SAMPLE_W-1:0]    rd_data_ff;
   logic                   rd_vld_ff, rd_vld_in;
   logic [AW-1:0]          wp_ff, wp_in, rd_idx_ff, rd_idx_in;
   logic [WIN_W-1:0]       fill_ff, fill_in, iss_left_ff, iss_left_in;
   logic [WIN_W-1:0]       proc_left_ff, proc_left_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic                   level_vld_ff, level_vld_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DIPS_W-1:0]      dips_ff, dips_in, last_dips_ff, last_dips_in;
   logic                   armed_ff, armed_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;

   logic [WIN_W-1:0]       win;
   logic                   wr_en, issue, walk_start;
   logic [WIN_W-1:0]       wp_ext, rd_ext, start_idx;
   logic signed [LEVEL_W:0] delta;
   logic signed [DIFF_W-1:0] diff, thr_fx, rearm_fx, lev_sum;
   logic                   hit;

   always_comb begin
      if (cfg.window == '0) begin
         win = WIN_W'(1);
      end else if (cfg.window > WIN_W'(DEPTH)) begin
         win = WIN_W'(DEPTH);
      end else begin
         win = cfg.window;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.op == OP_SAMPLE) begin
                  state_in = level_vld_ff ? ST_ADD : ST_RESP;
               end else begin
                  state_in = (level_vld_ff && fill_ff != '0) ? ST_WALK : ST_RESP;
               end
            end
         end
         ST_ADD:  state_in = ST_RESP;
         ST_WALK: begin
            if (rd_vld_ff && proc_left_ff == WIN_W'(1)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      walk_start = 1'b0;
      issue      = 1'b0;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop      = q_valid;
            wr_en      = q_valid && (q_item.op == OP_SAMPLE);
            walk_start = q_valid && (q_item.op == OP_QUERY);
         end
         ST_WALK: issue = (iss_left_ff != '0);
         ST_RESP: rsp_strobe = 1'b1;
         default: ;
      endcase
   end

   assign wp_ext   = WIN_W'(wp_ff);
   assign rd_ext   = WIN_W'(rd_idx_ff);
   assign start_idx = (wp_ext >= fill_ff) ? (wp_ext - fill_ff) : (win - (fill_ff - wp_ext));
   assign delta    = $signed({1'b0, q_item.sample, {FRAC_W{1'b0}}}) - $signed({1'b0, level_ff});
   assign lev_sum  = $signed({2'b0, level_ff}) + $signed(prod_ff[PROD_W-1:FRAC_W]);
   assign diff     = $signed({2'b0, level_ff}) - $signed({2'b0, rd_data_ff, {FRAC_W{1'b0}}});
   assign thr_fx   = $signed({2'b0, cfg.thr, {FRAC_W{1'b0}}});
   assign rearm_fx = $signed({2'b0, cfg.rearm, {FRAC_W{1'b0}}});
   assign hit      = (diff >= thr_fx);

   always_comb begin
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      level_in     = level_ff;
      level_vld_in = level_vld_ff;
      prod_in      = prod_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = issue;
      iss_left_in  = iss_left_ff;
      proc_left_in = proc_left_ff;
      dips_in      = dips_ff;
      armed_in     = armed_ff;
      last_dips_in = last_dips_ff;
      if (wr_en) begin
         wp_in   = (wp_ext + 1'b1 >= win) ? '0 : wp_ff + 1'b1;
         fill_in = (fill_ff < win) ? fill_ff + 1'b1 : fill_ff;
         if (total_ff != '1) begin
            total_in = total_ff + 1'b1;
         end
         if (!level_vld_ff) begin
            level_in     = {q_item.sample, {FRAC_W{1'b0}}};
            level_vld_in = 1'b1;
         end else begin
            prod_in = PROD_W'($signed({1'b0, cfg.weight}) * delta);
         end
      end
      if (state_ff == ST_ADD) begin
         level_in = lev_sum[LEVEL_W-1:0];
      end
      if (walk_start) begin
         if (!level_vld_ff || fill_ff == '0) begin
            last_dips_in = '0;
         end
         rd_idx_in    = AW'(start_idx);
         iss_left_in  = fill_ff;
         proc_left_in = fill_ff;
         dips_in      = '0;
         armed_in     = 1'b1;
      end
      if (issue) begin
         rd_idx_in   = (rd_ext + 1'b1 >= win) ? '0 : rd_idx_ff + 1'b1;
         iss_left_in = iss_left_ff - 1'b1;
      end
      if (state_ff == ST_WALK && rd_vld_ff) begin
         proc_left_in = proc_left_ff - 1'b1;
         if (hit) begin
            if (armed_ff) begin
               dips_in  = dips_ff + 1'b1;
               armed_in = 1'b0;
            end
         end else if (diff < rearm_fx) begin
            armed_in = 1'b1;
         end
         if (proc_left_ff == WIN_W'(1)) begin
            last_dips_in = dips_in;
         end
      end
      if (cfg.window_wr) begin
         wp_in   = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         level_ff     <= '0;
         level_vld_ff <= 1'b0;
         last_dips_ff <= '0;
         rd_vld_ff    <= 1'b0;
         iss_left_ff  <= '0;
         proc_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         level_ff     <= level_in;
         level_vld_ff <= level_vld_in;
         last_dips_ff <= last_dips_in;
         rd_vld_ff    <= rd_vld_in;
         iss_left_ff  <= iss_left_in;
         proc_left_ff <= proc_left_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      rd_idx_ff <= rd_idx_in;
      dips_ff   <= dips_in;
      armed_ff  <= armed_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring[wp_ff] <= q_item.sample;
      end
      rd_data_ff <= ring[rd_idx_ff];
   end

   assign rsp_dip_count     = last_dips_ff;
   assign rsp_average       = level_ff[LEVEL_W-1:FRAC_W];
   assign rsp_samples_held  = fill_ff;
   assign rsp_samples_taken = total_ff;

   `LDC_ASSERT_IMPL(a_fill_in_window, 1'b1, fill_ff <= win, "fill exceeds window")
   `LDC_ASSERT_IMPL(a_wp_in_window, 1'b1, wp_ext < win, "write pointer outside window")
   `LDC_ASSERT_IMPL(a_walk_order, state_ff == ST_WALK, iss_left_ff <= proc_left_ff, "read overrun")
   `LDC_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "strobe held")
endmodule
`default_nettype wire

// ----- rtl/light_dip_counter.sv -----
// Light dip counter top level: register port, front queue and back end.
// Depends on ldc_pkg, ldc_front and ldc_back.
//
// A sample command (req_kind 0) adds req_sample to the history ring and the moving average;
// a query (req_kind 1) counts dips over the ring. Every command gives exactly one result,
// shown for one cycle with rsp_strobe; the receiver cannot stall, so the result must be taken
// in that cycle. Commands go into a two-entry queue; busy is high only while it is full. In the
// back end a sample is multiplied in the idle state and added in the add state of the average
// update (the very first sample loads the average and skips the add); a query makes one ring
// read per held sample through the single read port of the ring memory, none if it is empty.
// Write the registers only while no command is in flight.
`default_nettype none
module light_dip_counter #(
   parameter int MAX_WINDOW = ldc_pkg::MAX_WINDOW_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  wire                            req_kind,
   input  wire [ldc_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                           rsp_strobe,
   output logic [ldc_pkg::DIPS_W-1:0]     rsp_dip_count,
   output logic [ldc_pkg::SAMPLE_W-1:0]   rsp_average,
   output logic [ldc_pkg::WIN_W-1:0]      rsp_samples_held,
   output logic [ldc_pkg::TOTAL_W-1:0]    rsp_samples_taken,
   input  wire                            psel,
   input  wire                            penable,
   input  wire                            pwrite,
   input  wire [ldc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire [ldc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ldc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import ldc_pkg::*;

   logic [WIN_W-1:0]    window_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic [THR_W-1:0]    thr_ff, rearm_ff;
   logic                csr_wr;
   logic [1:0]          csr_idx;
   ldc_cfg_type         cfg;
   logic                q_valid, q_pop;
   ldc_item_type        q_item;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RST;
         weight_ff <= WEIGHT_RST;
         thr_ff    <= THR_RST;
         rearm_ff  <= REARM_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_WINDOW: window_ff <= pwdata[WIN_W-1:0];
            REG_WEIGHT: weight_ff <= pwdata[WEIGHT_W-1:0];
            REG_THR:    thr_ff    <= pwdata[THR_W-1:0];
            REG_REARM:  rearm_ff  <= pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_WINDOW: prdata = CSR_DATA_W'(window_ff);
         REG_WEIGHT: prdata = CSR_DATA_W'(weight_ff);
         REG_THR:    prdata = CSR_DATA_W'(thr_ff);
         REG_REARM:  prdata = CSR_DATA_W'(rearm_ff);
         default:    prdata = '0;
      endcase
   end

   assign cfg = '{window:    window_ff,
                  window_wr: csr_wr && (csr_idx == REG_WINDOW),
                  weight:    weight_ff,
                  thr:       thr_ff,
                  rearm:     rearm_ff};

   ldc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_kind   (req_kind),
      .req_sample (req_sample),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   ldc_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_dip_count     (rsp_dip_count),
      .rsp_average       (rsp_average),
      .rsp_samples_held  (rsp_samples_held),
      .rsp_samples_taken (rsp_samples_taken)
   );
endmodule
`default_nettype wire
